[hdl/jtmf_pkg.sv]
// ----------------------------------------------------------------------------
// Joystick thruster mix framer package
// Shared types, register indexes, frame constants and arithmetic helpers.
// ----------------------------------------------------------------------------
package jtmf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned POS_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_FORWARD_CENTER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_CRAB_CENTER     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERTICAL_CENTER = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TURN_CENTER     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DEAD_ZONE       = 3'd4;

    localparam logic [BYTE_W-1:0] CENTER_RESET    = 8'd128;
    localparam logic [BYTE_W-1:0] DEAD_ZONE_RESET = 8'd15;

    localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0] MANIP_POS   = 8'h7D;
    localparam logic [BYTE_W-1:0] MANIP_NEG   = 8'h83;
    localparam logic [BYTE_W-1:0] MANIP_OFF   = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_POS_MAX = 8'h7E;
    localparam logic [BYTE_W-1:0] CMD_NEG_MAX = 8'h82;

    localparam logic [POS_W-1:0] POS_HEADER   = 3'd0;
    localparam logic [POS_W-1:0] POS_HR       = 3'd1;
    localparam logic [POS_W-1:0] POS_HL       = 3'd2;
    localparam logic [POS_W-1:0] POS_VR       = 3'd3;
    localparam logic [POS_W-1:0] POS_VL       = 3'd4;
    localparam logic [POS_W-1:0] POS_MANIP    = 3'd5;
    localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] forward_center;
        logic [BYTE_W-1:0] crab_center;
        logic [BYTE_W-1:0] vertical_center;
        logic [BYTE_W-1:0] turn_center;
        logic [BYTE_W-1:0] dead_zone;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] hr;
        logic [BYTE_W-1:0] hl;
        logic [BYTE_W-1:0] vr;
        logic [BYTE_W-1:0] vl;
        logic [BYTE_W-1:0] manip;
    } t_cmd_rec;

    function automatic logic signed [8:0] dead_band(
        input logic [BYTE_W-1:0] centre,
        input logic [BYTE_W-1:0] sample,
        input logic [BYTE_W-1:0] dz
    );
        logic signed [8:0] off;
        logic [8:0] mag;
        off = $signed({1'b0, centre}) - $signed({1'b0, sample});
        mag = off[8] ? 9'(-off) : 9'(off);
        if (mag < {1'b0, dz}) begin
            return 9'sd0;
        end
        return off;
    endfunction

    function automatic logic [BYTE_W-1:0] clamp_cmd(input logic signed [9:0] v);
        if (v > 10'sd126) begin
            return CMD_POS_MAX;
        end else if (v < -10'sd126) begin
            return CMD_NEG_MAX;
        end
        return v[7:0];
    endfunction

endpackage

[hdl/joystick_thruster_mix_framer.sv]
// ----------------------------------------------------------------------------
// Joystick thruster mix framer
// Turns joystick samples and switch states into framed thruster commands.
//
//   Channel   Handshake                   Payload
//   input     push / full                 four axis samples, two switches
//   result    empty / pop                 o_frame_byte, o_frame_end
//   config    i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// Every item yields seven result bytes, one per cycle while the result side
// pops, so the sustained rate is set by the byte serialiser in the back end.
// Items pass the front stages, the queue and the back-end output register.
// Reset is synchronous and restores all calibration registers.
// Front and back end stall independently through a two-entry command queue.
// ----------------------------------------------------------------------------
module joystick_thruster_mix_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_forward_sample,
    input  logic [7:0]  i_crab_sample,
    input  logic [7:0]  i_vertical_sample,
    input  logic [7:0]  i_turn_sample,
    input  logic        i_right_pressed,
    input  logic        i_left_pressed,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_frame_byte,
    output logic        o_frame_end,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    jtmf_pkg::t_cfg     r_cfg;
    jtmf_pkg::t_cmd_rec front_rec;
    jtmf_pkg::t_cmd_rec queue_rec;
    logic               front_valid;
    logic               queue_ready;
    logic               queue_valid;
    logic               back_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.forward_center  <= jtmf_pkg::CENTER_RESET;
            r_cfg.crab_center     <= jtmf_pkg::CENTER_RESET;
            r_cfg.vertical_center <= jtmf_pkg::CENTER_RESET;
            r_cfg.turn_center     <= jtmf_pkg::CENTER_RESET;
            r_cfg.dead_zone       <= jtmf_pkg::DEAD_ZONE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                jtmf_pkg::REG_FORWARD_CENTER:  r_cfg.forward_center  <= i_cfg_data;
                jtmf_pkg::REG_CRAB_CENTER:     r_cfg.crab_center     <= i_cfg_data;
                jtmf_pkg::REG_VERTICAL_CENTER: r_cfg.vertical_center <= i_cfg_data;
                jtmf_pkg::REG_TURN_CENTER:     r_cfg.turn_center     <= i_cfg_data;
                jtmf_pkg::REG_DEAD_ZONE:       r_cfg.dead_zone       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    jtmf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .push              (push),
        .full              (full),
        .i_forward_sample  (i_forward_sample),
        .i_crab_sample     (i_crab_sample),
        .i_vertical_sample (i_vertical_sample),
        .i_turn_sample     (i_turn_sample),
        .i_right_pressed   (i_right_pressed),
        .i_left_pressed    (i_left_pressed),
        .o_rec_valid       (front_valid),
        .o_rec             (front_rec),
        .i_rec_ready       (queue_ready)
    );

    jtmf_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .i_wr_data  (front_rec),
        .o_wr_ready (queue_ready),
        .o_rd_valid (queue_valid),
        .o_rd_data  (queue_rec),
        .i_rd_ready (back_ready)
    );

    jtmf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rec_valid  (queue_valid),
        .i_rec        (queue_rec),
        .o_rec_ready  (back_ready),
        .empty        (empty),
        .pop          (pop),
        .o_frame_byte (o_frame_byte),
        .o_frame_end  (o_frame_end)
    );

    // After the checksum byte leaves, the next byte shown must be a header.
    a_header_follows_end: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && o_frame_end) |=> (empty || o_frame_byte == jtmf_pkg::HEADER_BYTE)
    ) else $error("frame did not restart with a header");

    // A waiting result byte stays on the ports unchanged until its transfer.
    a_result_held: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_frame_byte) && $stable(o_frame_end))
    ) else $error("waiting result changed before its transfer");

    // The byte right after a header is never flagged as the end of a frame.
    a_end_not_first: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_frame_end) |=> (empty || !o_frame_end ||
            $past(o_frame_byte) != jtmf_pkg::HEADER_BYTE)
    ) else $error("frame end flagged right after a header");

endmodule

[hdl/jtmf_front.sv]
// ----------------------------------------------------------------------------
// Joystick thruster mix framer front end
// Takes joystick items, removes the dead band and forms the five commands.
// ----------------------------------------------------------------------------
module jtmf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  jtmf_pkg::t_cfg       i_cfg,
    input  logic                 push,
    output logic                 full,
    input  logic [7:0]           i_forward_sample,
    input  logic [7:0]           i_crab_sample,
    input  logic [7:0]           i_vertical_sample,
    input  logic [7:0]           i_turn_sample,
    input  logic                 i_right_pressed,
    input  logic                 i_left_pressed,
    output logic                 o_rec_valid,
    output jtmf_pkg::t_cmd_rec   o_rec,
    input  logic                 i_rec_ready
);

    logic               r_s1_valid;
    logic               r_s2_valid;
    logic signed [8:0]  r_fwd;
    logic signed [8:0]  r_crab;
    logic signed [8:0]  r_vert;
    logic signed [8:0]  r_turn;
    logic [7:0]         r_manip;
    jtmf_pkg::t_cmd_rec r_rec;
    logic               adv2;
    logic               adv1;
    logic               take;
    logic signed [9:0]  sum_hr;
    logic signed [9:0]  sum_hl;
    logic signed [9:0]  sum_vr;
    logic signed [9:0]  sum_vl;

    assign adv2 = !r_s2_valid || i_rec_ready;
    assign adv1 = !r_s1_valid || adv2;
    assign full = !adv1;
    assign take = push && adv1;

    assign sum_hr = {r_fwd[8], r_fwd} + {r_turn[8], r_turn};
    assign sum_hl = {r_fwd[8], r_fwd} - {r_turn[8], r_turn};
    assign sum_vr = {r_vert[8], r_vert} + {r_crab[8], r_crab};
    assign sum_vl = {r_vert[8], r_vert} - {r_crab[8], r_crab};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= push;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
        if (take) begin
            r_fwd  <= jtmf_pkg::dead_band(i_cfg.forward_center, i_forward_sample,
                                          i_cfg.dead_zone);
            r_crab <= jtmf_pkg::dead_band(i_cfg.crab_center, i_crab_sample,
                                          i_cfg.dead_zone);
            r_vert <= jtmf_pkg::dead_band(i_cfg.vertical_center, i_vertical_sample,
                                          i_cfg.dead_zone);
            r_turn <= jtmf_pkg::dead_band(i_cfg.turn_center, i_turn_sample,
                                          i_cfg.dead_zone);
            if (i_left_pressed) begin
                r_manip <= jtmf_pkg::MANIP_NEG;
            end else if (i_right_pressed) begin
                r_manip <= jtmf_pkg::MANIP_POS;
            end else begin
                r_manip <= jtmf_pkg::MANIP_OFF;
            end
        end
        if (adv2 && r_s1_valid) begin
            r_rec.hr    <= jtmf_pkg::clamp_cmd(sum_hr);
            r_rec.hl    <= jtmf_pkg::clamp_cmd(sum_hl);
            r_rec.vr    <= jtmf_pkg::clamp_cmd(sum_vr);
            r_rec.vl    <= jtmf_pkg::clamp_cmd(sum_vl);
            r_rec.manip <= r_manip;
        end
    end

    assign o_rec_valid = r_s2_valid;
    assign o_rec       = r_rec;

endmodule

[hdl/jtmf_fifo.sv]
// ----------------------------------------------------------------------------
// Joystick thruster mix framer command queue
// Two-entry queue of mixed command records between front and back end.
// ----------------------------------------------------------------------------
module jtmf_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_valid,
    input  jtmf_pkg::t_cmd_rec   i_wr_data,
    output logic                 o_wr_ready,
    output logic                 o_rd_valid,
    output jtmf_pkg::t_cmd_rec   o_rd_data,
    input  logic                 i_rd_ready
);

    jtmf_pkg::t_cmd_rec r_mem [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               wr_en;
    logic               rd_en;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign wr_en      = i_wr_valid && o_wr_ready;
    assign rd_en      = i_rd_ready && o_rd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (rd_en) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - 2'd1;
            end
        end
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

[hdl/jtmf_back.sv]
// ----------------------------------------------------------------------------
// Joystick thruster mix framer back end
// Serialises one command record into a seven-byte frame with checksum.
// ----------------------------------------------------------------------------
module jtmf_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rec_valid,
    input  jtmf_pkg::t_cmd_rec   i_rec,
    output logic                 o_rec_ready,
    output logic                 empty,
    input  logic                 pop,
    output logic [7:0]           o_frame_byte,
    output logic                 o_frame_end
);

    jtmf_pkg::t_cmd_rec r_rec;
    logic                r_active;
    logic [2:0]          r_pos;
    logic [7:0]          r_sum;
    logic                r_out_valid;
    logic [7:0]          r_out_byte;
    logic                r_out_end;
    logic                out_adv;
    logic                emit;
    logic                last;
    logic                load;
    logic [7:0]          sel_byte;

    assign out_adv     = !r_out_valid || pop;
    assign emit        = r_active && out_adv;
    assign last        = (r_pos == jtmf_pkg::POS_CHECKSUM);
    assign o_rec_ready = !r_active || (emit && last);
    assign load        = o_rec_ready && i_rec_valid;

    always_comb begin
        unique case (r_pos)
            jtmf_pkg::POS_HEADER:   sel_byte = jtmf_pkg::HEADER_BYTE;
            jtmf_pkg::POS_HR:       sel_byte = r_rec.hr;
            jtmf_pkg::POS_HL:       sel_byte = r_rec.hl;
            jtmf_pkg::POS_VR:       sel_byte = r_rec.vr;
            jtmf_pkg::POS_VL:       sel_byte = r_rec.vl;
            jtmf_pkg::POS_MANIP:    sel_byte = r_rec.manip;
            jtmf_pkg::POS_CHECKSUM: sel_byte = r_sum;
            default:                sel_byte = jtmf_pkg::HEADER_BYTE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pos       <= jtmf_pkg::POS_HEADER;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_active <= 1'b1;
                r_pos    <= jtmf_pkg::POS_HEADER;
            end else if (emit) begin
                if (last) begin
                    r_active <= 1'b0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
        end
        if (load) begin
            r_rec <= i_rec;
            r_sum <= 8'd0;
        end else if (emit && (r_pos != jtmf_pkg::POS_HEADER) && !last) begin
            r_sum <= r_sum + sel_byte;
        end
        if (emit) begin
            r_out_byte <= sel_byte;
            r_out_end  <= last;
        end
    end

    assign empty        = !r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_frame_end  = r_out_end;

endmodule

[bench/joystick_thruster_mix_framer_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick thruster mix framer checker
// Watches the input, result and register write channels of the framer. It
// keeps its own copy of the calibration registers and predicts the seven
// frame bytes of every accepted joystick item. Each result transfer is
// compared with the oldest predicted byte, and the mismatch count is passed
// back to the testbench top.
// ----------------------------------------------------------------------------
module joystick_thruster_mix_framer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  i_forward_sample,
    input  logic [7:0]  i_crab_sample,
    input  logic [7:0]  i_vertical_sample,
    input  logic [7:0]  i_turn_sample,
    input  logic        i_right_pressed,
    input  logic        i_left_pressed,
    input  logic        empty,
    input  logic        pop,
    input  logic [7:0]  o_frame_byte,
    input  logic        o_frame_end,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output int          errors,
    output int          bytes_waiting,
    output int          bytes_checked
);

    localparam int THRUST_LIMIT = 126;
    localparam int MANIP_LEVEL = 125;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [jtmf_pkg::BYTE_W-1:0] value;
        logic                        last;
    } frame_entry_t;

    jtmf_pkg::t_cfg calibration;
    frame_entry_t   expected_bytes[$];
    frame_entry_t   head;
    int             mismatches = 0;
    int             checked = 0;

    function automatic logic signed [9:0] band_offset(
        input logic [7:0] rest,
        input logic [7:0] reading,
        input logic [7:0] band
    );
        logic signed [9:0] diff;
        diff = $signed({2'b00, rest}) - $signed({2'b00, reading});
        if ((diff < 0 ? -diff : diff) < $signed({2'b00, band})) begin
            return '0;
        end
        return diff;
    endfunction

    function automatic logic [7:0] thrust_limit(input logic signed [10:0] v);
        if (v > THRUST_LIMIT) begin
            return 8'(THRUST_LIMIT);
        end
        if (v < -THRUST_LIMIT) begin
            return 8'(-THRUST_LIMIT);
        end
        return v[7:0];
    endfunction

    function automatic void queue_frame(
        input logic [7:0] fwd_raw,
        input logic [7:0] crab_raw,
        input logic [7:0] vert_raw,
        input logic [7:0] turn_raw,
        input logic       right_sw,
        input logic       left_sw
    );
        logic signed [9:0] fwd;
        logic signed [9:0] crab;
        logic signed [9:0] vert;
        logic signed [9:0] turn;
        logic [7:0]        cmd[5];
        logic [7:0]        sum;
        fwd  = band_offset(calibration.forward_center, fwd_raw, calibration.dead_zone);
        crab = band_offset(calibration.crab_center, crab_raw, calibration.dead_zone);
        vert = band_offset(calibration.vertical_center, vert_raw, calibration.dead_zone);
        turn = band_offset(calibration.turn_center, turn_raw, calibration.dead_zone);
        cmd[0] = thrust_limit(11'(fwd) + 11'(turn));
        cmd[1] = thrust_limit(11'(fwd) - 11'(turn));
        cmd[2] = thrust_limit(11'(vert) + 11'(crab));
        cmd[3] = thrust_limit(11'(vert) - 11'(crab));
        if (left_sw) begin
            cmd[4] = 8'(-MANIP_LEVEL);
        end else if (right_sw) begin
            cmd[4] = 8'(MANIP_LEVEL);
        end else begin
            cmd[4] = '0;
        end
        expected_bytes.push_back('{jtmf_pkg::HEADER_BYTE, 1'b0});
        sum = '0;
        for (int k = 0; k < 5; k++) begin
            expected_bytes.push_back('{cmd[k], 1'b0});
            sum = sum + cmd[k];
        end
        expected_bytes.push_back('{sum, 1'b1});
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            calibration = '{jtmf_pkg::CENTER_RESET, jtmf_pkg::CENTER_RESET,
                            jtmf_pkg::CENTER_RESET, jtmf_pkg::CENTER_RESET,
                            jtmf_pkg::DEAD_ZONE_RESET};
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    jtmf_pkg::REG_FORWARD_CENTER:  calibration.forward_center = i_cfg_data;
                    jtmf_pkg::REG_CRAB_CENTER:     calibration.crab_center = i_cfg_data;
                    jtmf_pkg::REG_VERTICAL_CENTER: calibration.vertical_center = i_cfg_data;
                    jtmf_pkg::REG_TURN_CENTER:     calibration.turn_center = i_cfg_data;
                    jtmf_pkg::REG_DEAD_ZONE:       calibration.dead_zone = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                checked++;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("%0t: frame byte %02h (end %0b) arrived with none expected",
                                 $time, o_frame_byte, o_frame_end);
                    end
                end else begin
                    head = expected_bytes.pop_front();
                    if (head.value !== o_frame_byte || head.last !== o_frame_end) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: frame byte expected %02h end %0b, got %02h end %0b",
                                     $time, head.value, head.last, o_frame_byte,
                                     o_frame_end);
                        end
                    end
                end
            end
            if (push && !full) begin
                queue_frame(i_forward_sample, i_crab_sample, i_vertical_sample,
                            i_turn_sample, i_right_pressed, i_left_pressed);
            end
        end
        errors <= mismatches;
        bytes_waiting <= expected_bytes.size();
        bytes_checked <= checked;
    end

endmodule

[bench/joystick_thruster_mix_framer_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joystick thruster mix framer testbench
// Drives joystick items and calibration settings into the framer with random
// gaps on both the input and the result side. A separate checker predicts
// every frame byte; this top makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module joystick_thruster_mix_framer_tb;

    localparam int CLOCK_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 40;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_forward_sample = '0;
    logic [7:0] i_crab_sample = '0;
    logic [7:0] i_vertical_sample = '0;
    logic [7:0] i_turn_sample = '0;
    logic       i_right_pressed = 1'b0;
    logic       i_left_pressed = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_frame_byte;
    logic       o_frame_end;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    int             errors;
    int             bytes_waiting;
    int             bytes_checked;
    int             cycles = 0;
    int             items_sent = 0;
    int             cfg_writes = 0;
    int             settings_used = 1;
    int             send_calm = 0;
    int             pop_calm = 0;
    jtmf_pkg::t_cfg setting = '{jtmf_pkg::CENTER_RESET, jtmf_pkg::CENTER_RESET,
                                jtmf_pkg::CENTER_RESET, jtmf_pkg::CENTER_RESET,
                                jtmf_pkg::DEAD_ZONE_RESET};

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    joystick_thruster_mix_framer dut (.*);

    joystick_thruster_mix_framer_checker checker_i (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CLOCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            calm = $urandom_range(6, 30);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    initial begin
        int gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_wait(pop_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    task automatic send_item(
        input logic [7:0] fwd,
        input logic [7:0] crab,
        input logic [7:0] vert,
        input logic [7:0] turn,
        input logic       right_sw,
        input logic       left_sw
    );
        int gap;
        i_forward_sample <= fwd;
        i_crab_sample <= crab;
        i_vertical_sample <= vert;
        i_turn_sample <= turn;
        i_right_pressed <= right_sw;
        i_left_pressed <= left_sw;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        items_sent++;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random();
        logic [7:0] rest[4];
        logic [7:0] raw[4];
        logic [7:0] step;
        rest = '{setting.forward_center, setting.crab_center, setting.vertical_center,
                 setting.turn_center};
        for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 3)) inside
                0, 1: raw[k] = 8'($urandom);
                2: raw[k] = rest[k] + 8'($urandom_range(0, 8)) - 8'd4;
                default: begin
                    step = setting.dead_zone + 8'($urandom_range(0, 3)) - 8'd2;
                    raw[k] = $urandom_range(0, 1) ? rest[k] + step : rest[k] - step;
                end
            endcase
        end
        send_item(raw[0], raw[1], raw[2], raw[3], 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    // Lets every predicted byte leave the block before the sender carries on.
    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (bytes_waiting != 0);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] value);
        i_cfg_index <= idx;
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
    endtask

    task automatic apply_setting(input jtmf_pkg::t_cfg s);
        cfg_write(jtmf_pkg::REG_FORWARD_CENTER, s.forward_center);
        cfg_write(jtmf_pkg::REG_CRAB_CENTER, s.crab_center);
        cfg_write(jtmf_pkg::REG_VERTICAL_CENTER, s.vertical_center);
        cfg_write(jtmf_pkg::REG_TURN_CENTER, s.turn_center);
        cfg_write(jtmf_pkg::REG_DEAD_ZONE, s.dead_zone);
        i_cfg_valid <= 1'b0;
        setting = s;
        settings_used++;
    endtask

    task automatic random_run(input int count);
        int pause_at;
        pause_at = $urandom_range(5, count - 5);
        for (int n = 0; n < count; n++) begin
            if (n == pause_at) begin
                drain();
            end
            send_random();
        end
        drain();
    endtask

    function automatic jtmf_pkg::t_cfg random_setting(input logic [7:0] band);
        jtmf_pkg::t_cfg s;
        s.forward_center = 8'($urandom);
        s.crab_center = 8'($urandom);
        s.vertical_center = 8'($urandom);
        s.turn_center = 8'($urandom);
        s.dead_zone = band;
        return s;
    endfunction

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Writes to indexes past the register list must leave the defaults alone.
        for (int k = jtmf_pkg::REG_DEAD_ZONE + 1; k < 2 ** jtmf_pkg::REG_IDX_W; k++) begin
            cfg_write(jtmf_pkg::REG_IDX_W'(k), 8'($urandom));
        end
        i_cfg_valid <= 1'b0;

        send_item(8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0);
        send_item(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_item(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_item(8'd0, 8'd255, 8'd0, 8'd255, 1'b0, 1'b1);
        send_item(8'd255, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1);
        send_item(8'd113, 8'd113, 8'd113, 8'd113, 1'b1, 1'b0);
        send_item(8'd114, 8'd114, 8'd114, 8'd114, 1'b0, 1'b1);
        send_item(8'd143, 8'd143, 8'd143, 8'd143, 1'b0, 1'b0);
        send_item(8'd142, 8'd142, 8'd142, 8'd142, 1'b1, 1'b1);
        send_item(8'd113, 8'd142, 8'd143, 8'd114, 1'b1, 1'b0);
        send_item(8'd60, 8'd200, 8'd20, 8'd240, 1'b0, 1'b1);
        send_item(8'd0, 8'd128, 8'd255, 8'd128, 1'b1, 1'b0);
        send_item(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0, 1'b0);
        send_item(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1, 1'b1);
        send_item(8'd1, 8'd254, 8'd127, 8'd129, 1'b0, 1'b1);
        drain();

        apply_setting('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_item(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_item(8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 1'b0);
        random_run(RANDOM_PER_PHASE);

        apply_setting('{8'd255, 8'd255, 8'd255, 8'd255, 8'd255});
        send_item(8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        send_item(8'd1, 8'd0, 8'd1, 8'd0, 1'b1, 1'b0);
        random_run(RANDOM_PER_PHASE);

        apply_setting(random_setting(8'd0));
        random_run(RANDOM_PER_PHASE);

        apply_setting('{8'd128, 8'd128, 8'd128, 8'd128, 8'd1});
        random_run(RANDOM_PER_PHASE);

        apply_setting(random_setting(8'($urandom_range(0, 64))));
        random_run(RANDOM_PER_PHASE);

        apply_setting(random_setting(8'($urandom)));
        random_run(RANDOM_PER_PHASE);

        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d joystick items under %0d calibration settings (%0d register writes).",
                 items_sent, settings_used, cfg_writes);
        $display("Compared %0d frame bytes, %0d of them wrong or unexpected.",
                 bytes_checked, errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
